[hw/rtl/rpmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the reference-counted page map cache.
// No dependencies; used by refcounted_page_map_cache.
package rpmc_pkg;

  localparam int ADDR_W   = 64;
  localparam int FRAME_W  = 52;
  localparam int LIMIT_W  = 7;
  localparam int REFS_W   = 16;
  localparam int STAMP_W  = 32;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_FINAL = 1'b0,
    KIND_UNMAP = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MAP_FAILED  = 3'd1,
    ST_ABSENT      = 3'd2,
    ST_REL_UNKNOWN = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef struct packed {
    logic               operation;
    logic [FRAME_W-1:0] frame_number;
    logic [ADDR_W-1:0]  mapped_address;
    logic               map_ok;
    logic               page_present;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         status;
    logic [FRAME_W-1:0] out_frame;
    logic [ADDR_W-1:0]  out_address;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_MISS,
    S_EV_SCAN,
    S_EV_EMIT,
    S_INSERT,
    S_FINAL
  } state_t;

endpackage

[hw/rtl/refcounted_page_map_cache.sv]
`timescale 1ns / 1ps
// Flow: a scan reads one slot a cycle through the registered read port. A lookup scan ends in
// a hit, which writes back and emits its final item, or a miss; an acquire miss inserts, which may end in an
// unmap transfer and a final status. Each eviction round is another scan plus its unmap
// transfer, up to limit / 2 rounds. An output stall holds any state that waits to emit an item.
// Items are taken one at a time: in_stall is high whenever the state machine is not idle.
// Reset (rst, synchronous): valid bits, entry count and stamp clear, limit to ENTRIES.
module refcounted_page_map_cache #(
  parameter int ENTRIES    = 64,
  parameter int MIN_LIMIT  = 50,
  parameter int FRAME_BITS = 52
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpmc_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rpmc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  import rpmc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  // Frames are kept at FRAME_BITS, never wider than the frame field itself.
  localparam int FW = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef struct packed {
    logic [FW-1:0]      frame;
    logic [ADDR_W-1:0]  addr;
    logic [REFS_W-1:0]  refs;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Entry memory: one write port, one registered read port. Valid bits live in flops so
  // reset can clear them at once.
  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic [IW-1:0] rd_idx;
  logic rd_vld;
  logic mem_we;
  logic [IW-1:0] mem_wa;
  entry_t mem_wd;

  logic [ENTRIES-1:0] valid;
  logic [STAMP_W-1:0] stamp_counter;
  logic [LIMIT_W-1:0] total;
  logic [LIMIT_W-1:0] limit;

  state_t state, state_next;
  in_item_t req;
  logic [FW-1:0] req_frame;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] hit_idx;
  entry_t hit_q;
  logic best_found;
  logic [STAMP_W-1:0] best_age;
  logic [5:0] ev_count;
  logic [5:0] budget;

  logic out_free, out_load;
  out_item_t out_item;
  logic rd_hit, ev_take, scan_end, scanning;
  logic [STAMP_W-1:0] rd_age;
  logic [IW-1:0] free_idx;
  logic free_any;

  assign req_frame = req.frame_number[FW-1:0];
  assign budget    = limit[6:1];
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign scanning  = (state == S_LOOKUP) || (state == S_EV_SCAN);
  assign scan_end  = rd_vld && (rd_idx == LAST_IDX);

  // A lookup matches by address for a release and by frame for an acquire.
  assign rd_hit = rd_vld && valid[rd_idx] &&
                  ((req.operation == OP_RELEASE) ? (rd_q.addr == req.mapped_address)
                                                 : (rd_q.frame == req_frame));

  // Age is taken modulo 2^32 so the eviction order survives stamp wrap. A strict compare
  // keeps the lowest slot among equal ages.
  assign rd_age  = stamp_counter - rd_q.stamp;
  assign ev_take = rd_vld && valid[rd_idx] && (rd_q.refs == '0) &&
                   (!best_found || (rd_age > best_age));

  // Lowest free slot for an insert.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_item   = '0;
    mem_we     = 1'b0;
    mem_wa     = hit_idx;
    mem_wd     = hit_q;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (rd_hit) begin
          state_next = S_HIT;
        end else if (scan_end) begin
          state_next = S_MISS;
        end
      end
      S_HIT: begin
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = 1'b1;
          out_item = '{kind: KIND_FINAL, status: ST_OK, out_frame: FRAME_W'(hit_q.frame),
                       out_address: hit_q.addr, last: 1'b1};
          if (req.operation == OP_RELEASE) begin
            if (hit_q.refs != '0) begin
              mem_wd.refs = hit_q.refs - 1'b1;
            end
          end else begin
            out_item.out_frame = FRAME_W'(req_frame);
            mem_wd.stamp = stamp_counter;
            if (hit_q.refs != '1) begin
              mem_wd.refs = hit_q.refs + 1'b1;
            end
          end
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (req.operation == OP_RELEASE) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_item   = '{kind: KIND_FINAL, status: ST_REL_UNKNOWN, out_frame: '0,
                           out_address: req.mapped_address, last: 1'b1};
            state_next = S_IDLE;
          end
        end else if (total >= limit) begin
          state_next = S_EV_SCAN;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_EV_SCAN: begin
        if (scan_end) begin
          state_next = (best_found || ev_take) ? S_EV_EMIT : S_INSERT;
        end
      end
      S_EV_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item   = '{kind: KIND_UNMAP, status: ST_OK, out_frame: FRAME_W'(hit_q.frame),
                         out_address: hit_q.addr, last: 1'b0};
          state_next = ((ev_count + 6'd1) == budget) ? S_INSERT : S_EV_SCAN;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!req.map_ok) begin
            out_item   = '{kind: KIND_FINAL, status: ST_MAP_FAILED,
                           out_frame: FRAME_W'(req_frame), out_address: '0, last: 1'b1};
            state_next = S_IDLE;
          end else if (!req.page_present || !free_any) begin
            out_item   = '{kind: KIND_UNMAP, status: ST_OK, out_frame: FRAME_W'(req_frame),
                           out_address: req.mapped_address, last: 1'b0};
            state_next = S_FINAL;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = free_idx;
            mem_wd     = '{frame: req_frame, addr: req.mapped_address,
                           refs: REFS_W'(1), stamp: stamp_counter};
            out_item   = '{kind: KIND_FINAL, status: ST_OK, out_frame: FRAME_W'(req_frame),
                           out_address: req.mapped_address, last: 1'b1};
            state_next = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item   = '{kind: KIND_FINAL,
                         status: req.page_present ? ST_FULL : ST_ABSENT,
                         out_frame: FRAME_W'(req_frame), out_address: '0, last: 1'b1};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The state machine never writes while a scan reads, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q   <= mem[scan_idx];
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      stamp_counter <= '0;
      total         <= '0;
      limit         <= LIMIT_W'(ENTRIES);
      rd_vld        <= 1'b0;
      best_found    <= 1'b0;
    end else begin
      rd_vld <= scanning && (state_next == state);
      if (cfg_valid && (cfg_data >= LIMIT_W'(MIN_LIMIT))) begin
        limit <= (cfg_data > LIMIT_W'(ENTRIES)) ? LIMIT_W'(ENTRIES) : cfg_data;
      end
      if (state_next == S_EV_SCAN && state != S_EV_SCAN) begin
        best_found <= 1'b0;
      end else if (state == S_EV_SCAN && ev_take) begin
        best_found <= 1'b1;
      end
      if (out_load && state == S_EV_EMIT) begin
        valid[hit_idx] <= 1'b0;
        total          <= total - 1'b1;
      end
      if (out_load && ((state == S_HIT && req.operation == OP_ACQUIRE) ||
                       state == S_INSERT)) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
      if (out_load && state == S_INSERT && req.map_ok && req.page_present && free_any) begin
        valid[free_idx] <= 1'b1;
        total           <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req <= in_data;
    end
    if ((state_next == S_LOOKUP || state_next == S_EV_SCAN) && state_next != state) begin
      scan_idx <= '0;
    end else if (scanning && scan_idx != LAST_IDX) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (state == S_LOOKUP && rd_hit) begin
      hit_idx <= rd_idx;
      hit_q   <= rd_q;
    end
    if (state == S_EV_SCAN && ev_take) begin
      hit_idx  <= rd_idx;
      hit_q    <= rd_q;
      best_age <= rd_age;
    end
    if (state == S_MISS) begin
      ev_count <= '0;
    end else if (state == S_EV_EMIT && out_load) begin
      ev_count <= ev_count + 6'd1;
    end
  end

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= LIMIT_W'(ENTRIES))
    else $error("entry count above table size");
  a_total_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(total))
    else $error("entry count disagrees with valid bits");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !(state == S_IDLE && mem_we))
    else $error("memory write while idle");
  a_evict_unref: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV_EMIT) |-> (valid[hit_idx] && hit_q.refs == '0))
    else $error("evicting a referenced or empty entry");
`endif

endmodule
